### hw/rtl/tcpr_pkg.sv
package tcpr_pkg;

    typedef enum logic [2:0] {
        KIND_IGNORE     = 3'd0,
        KIND_SYN        = 3'd1,
        KIND_ACK        = 3'd2,
        KIND_RETRANSMIT = 3'd3,
        KIND_FIN        = 3'd4,
        KIND_RST        = 3'd5,
        KIND_DATA       = 3'd6
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TAIL_RD,
        S_TAIL_CHK,
        S_FIND_RD,
        S_FIND_CHK,
        S_MOVE_RD,
        S_MOVE_CHK,
        S_PLACE,
        S_POP_RD,
        S_POP_CHK
    } t_state;

    localparam int SEQ_BITS = 32;
    localparam int LEN_BITS = 16;
    localparam int STAMP_BITS = 32;
    localparam int HANDLE_PORT_BITS = 16;

    // Wrap-aware ordering: a is after b when a - b, read as signed, is positive.
    function automatic logic seq_after(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return (d != 32'd0) && !d[31];
    endfunction

    function automatic logic seq_not_before(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return !d[31];
    endfunction

endpackage

### hw/rtl/tcpr_store.sv
module tcpr_store #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 99
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/tcpr_classify.sv
module tcpr_classify (
    input  logic [31:0]        i_seq,
    input  logic [15:0]        i_total_len,
    input  logic [3:0]         i_ip_words,
    input  logic [3:0]         i_tcp_words,
    input  logic               i_syn,
    input  logic               i_ack,
    input  logic               i_fin,
    input  logic               i_rst,
    input  logic [31:0]        i_expected,
    output logic [15:0]        o_len,
    output tcpr_pkg::t_kind    o_kind
);

    logic [6:0] hdr;

    always_comb begin
        hdr = {1'b0, i_ip_words, 2'b00} + {1'b0, i_tcp_words, 2'b00};
        o_len = (i_total_len > 16'(hdr)) ? (i_total_len - 16'(hdr)) : 16'd0;
        if (i_syn) begin
            o_kind = tcpr_pkg::KIND_SYN;
        end else if (i_ack && !i_fin && (o_len == 16'd0)) begin
            o_kind = tcpr_pkg::KIND_ACK;
        end else if (tcpr_pkg::seq_after(i_expected, i_seq)) begin
            o_kind = tcpr_pkg::KIND_RETRANSMIT;
        end else if (i_fin) begin
            o_kind = tcpr_pkg::KIND_FIN;
        end else if (i_rst) begin
            o_kind = tcpr_pkg::KIND_RST;
        end else begin
            o_kind = tcpr_pkg::KIND_DATA;
        end
    end

endmodule

### hw/rtl/tcp_sequence_reorder_buffer.sv
// Channel   Direction  Handshake                        Payload
// command   in         start high while busy low        i_operation .. i_stamp
// result    out        o_done high for one cycle        o_push_kind .. o_out_stamp
//
// Records sit in one circular memory in sequence order, read through a registered port.
// A pop passes POP_RD and POP_CHK; a rejected, full or empty-store item is answered from IDLE.
// A push into an empty store goes to PLACE; an append at the tail passes TAIL_RD, TAIL_CHK, PLACE.
// Any other push adds a FIND_RD/FIND_CHK step (one memory read) per entry searched from the head
// and a MOVE_RD/MOVE_CHK step (one memory read and one write) per entry moved up.
// Synchronous active-low reset empties the store and clears the expected number.
// The receiver cannot stall; o_done is high for exactly one cycle.
module tcp_sequence_reorder_buffer #(
    parameter int STORE_DEPTH = 64,
    parameter int HANDLE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_operation,
    input  logic        i_accept,
    input  logic [31:0] i_seq_number,
    input  logic [15:0] i_ip_total_len,
    input  logic [3:0]  i_ip_header_words,
    input  logic [3:0]  i_tcp_header_words,
    input  logic        i_flag_syn,
    input  logic        i_flag_ack,
    input  logic        i_flag_fin,
    input  logic        i_flag_rst,
    input  logic [15:0] i_handle,
    input  logic [31:0] i_stamp,
    output logic        o_done,
    output logic [2:0]  o_push_kind,
    output logic        o_dropped,
    output logic        o_popped,
    output logic [31:0] o_out_seq,
    output logic [15:0] o_out_len,
    output logic [2:0]  o_out_kind,
    output logic [15:0] o_out_handle,
    output logic [31:0] o_out_stamp
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int PW = CW + 1;
    localparam int HB = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;
    localparam int RW = 32 + 16 + 3 + 32 + HB;

    tcpr_pkg::t_state r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [31:0]   r_exp, n_exp;
    logic [AW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_pos, n_pos;
    logic [31:0]   r_seq, n_seq;
    logic [15:0]   r_len, n_len;
    tcpr_pkg::t_kind r_kind, n_kind;
    logic [HB-1:0] r_hdl, n_hdl;
    logic [31:0]   r_stamp, n_stamp;

    logic          r_done, n_done;
    logic [2:0]    r_push_kind, n_push_kind;
    logic          r_dropped, n_dropped;
    logic          r_popped, n_popped;
    logic [31:0]   r_res_seq, n_res_seq;
    logic [15:0]   r_res_len, n_res_len;
    logic [2:0]    r_res_kind, n_res_kind;
    logic [HB-1:0] r_res_hdl, n_res_hdl;
    logic [31:0]   r_res_stamp, n_res_stamp;

    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [RW-1:0] mem_wdata, mem_rdata;

    logic [15:0]     cls_len;
    tcpr_pkg::t_kind cls_kind;

    logic [31:0]   rd_seq, rd_stamp, rd_end;
    logic [15:0]   rd_len;
    logic [2:0]    rd_kind;
    logic [HB-1:0] rd_hdl;
    logic          accepted;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] k);
        logic [PW-1:0] s;
        s = PW'(head) + PW'(k);
        if (s >= PW'(STORE_DEPTH)) begin
            s = s - PW'(STORE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    tcpr_classify u_classify (
        .i_seq       (i_seq_number),
        .i_total_len (i_ip_total_len),
        .i_ip_words  (i_ip_header_words),
        .i_tcp_words (i_tcp_header_words),
        .i_syn       (i_flag_syn),
        .i_ack       (i_flag_ack),
        .i_fin       (i_flag_fin),
        .i_rst       (i_flag_rst),
        .i_expected  (r_exp),
        .o_len       (cls_len),
        .o_kind      (cls_kind)
    );

    tcpr_store #(
        .DEPTH (STORE_DEPTH),
        .WIDTH (RW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign rd_seq   = mem_rdata[RW-1 -: 32];
    assign rd_len   = mem_rdata[RW-33 -: 16];
    assign rd_kind  = mem_rdata[RW-49 -: 3];
    assign rd_stamp = mem_rdata[HB +: 32];
    assign rd_hdl   = mem_rdata[HB-1:0];
    assign rd_end   = rd_seq + 32'(rd_len);

    assign busy     = (r_state != tcpr_pkg::S_IDLE);
    assign accepted = start && !busy;

    always_comb begin
        n_state = r_state;
        case (r_state)
            tcpr_pkg::S_IDLE: begin
                if (accepted) begin
                    if (i_operation) begin
                        if (r_count != CW'(0)) begin
                            n_state = tcpr_pkg::S_POP_RD;
                        end
                    end else if (i_accept && (r_count != CW'(STORE_DEPTH))) begin
                        n_state = (r_count == CW'(0)) ? tcpr_pkg::S_PLACE
                                                      : tcpr_pkg::S_TAIL_RD;
                    end
                end
            end
            tcpr_pkg::S_TAIL_RD: n_state = tcpr_pkg::S_TAIL_CHK;
            tcpr_pkg::S_TAIL_CHK: begin
                n_state = tcpr_pkg::seq_not_before(r_seq, rd_seq) ? tcpr_pkg::S_PLACE
                                                                  : tcpr_pkg::S_FIND_RD;
            end
            tcpr_pkg::S_FIND_RD: n_state = tcpr_pkg::S_FIND_CHK;
            tcpr_pkg::S_FIND_CHK: begin
                if (tcpr_pkg::seq_after(rd_seq, r_seq)) begin
                    n_state = tcpr_pkg::S_MOVE_RD;
                end else if (CW'(r_idx) == r_count - CW'(1)) begin
                    n_state = tcpr_pkg::S_PLACE;
                end else begin
                    n_state = tcpr_pkg::S_FIND_RD;
                end
            end
            tcpr_pkg::S_MOVE_RD: n_state = tcpr_pkg::S_MOVE_CHK;
            tcpr_pkg::S_MOVE_CHK: begin
                n_state = (r_idx == r_pos) ? tcpr_pkg::S_PLACE : tcpr_pkg::S_MOVE_RD;
            end
            tcpr_pkg::S_PLACE:   n_state = tcpr_pkg::S_IDLE;
            tcpr_pkg::S_POP_RD:  n_state = tcpr_pkg::S_POP_CHK;
            tcpr_pkg::S_POP_CHK: n_state = tcpr_pkg::S_IDLE;
            default:             n_state = tcpr_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_head = r_head;
        n_count = r_count;
        n_exp = r_exp;
        n_idx = r_idx;
        n_pos = r_pos;
        n_seq = r_seq;
        n_len = r_len;
        n_kind = r_kind;
        n_hdl = r_hdl;
        n_stamp = r_stamp;
        n_done = 1'b0;
        n_push_kind = r_push_kind;
        n_dropped = r_dropped;
        n_popped = r_popped;
        n_res_seq = r_res_seq;
        n_res_len = r_res_len;
        n_res_kind = r_res_kind;
        n_res_hdl = r_res_hdl;
        n_res_stamp = r_res_stamp;
        mem_we = 1'b0;
        mem_waddr = phys(r_head, CW'(r_pos));
        mem_wdata = {r_seq, r_len, r_kind, r_stamp, r_hdl};
        mem_raddr = phys(r_head, CW'(r_idx));
        case (r_state)
            tcpr_pkg::S_IDLE: begin
                mem_raddr = r_head;
                if (accepted) begin
                    n_seq = i_seq_number;
                    n_len = cls_len;
                    n_kind = cls_kind;
                    n_hdl = i_handle[HB-1:0];
                    n_stamp = i_stamp;
                    n_pos = AW'(r_count);
                    n_push_kind = tcpr_pkg::KIND_IGNORE;
                    n_dropped = 1'b0;
                    n_popped = 1'b0;
                    n_res_seq = '0;
                    n_res_len = '0;
                    n_res_kind = '0;
                    n_res_hdl = '0;
                    n_res_stamp = '0;
                    if (i_operation) begin
                        n_done = (r_count == CW'(0));
                    end else if (!i_accept) begin
                        n_done = 1'b1;
                    end else begin
                        if (i_flag_syn) begin
                            n_exp = i_seq_number;
                        end
                        if (r_count == CW'(STORE_DEPTH)) begin
                            n_dropped = 1'b1;
                            n_done = 1'b1;
                        end
                    end
                end
            end
            tcpr_pkg::S_TAIL_RD: begin
                mem_raddr = phys(r_head, r_count - CW'(1));
            end
            tcpr_pkg::S_TAIL_CHK: begin
                n_idx = '0;
            end
            tcpr_pkg::S_FIND_CHK: begin
                if (tcpr_pkg::seq_after(rd_seq, r_seq)) begin
                    n_pos = r_idx;
                    n_idx = AW'(r_count - CW'(1));
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            tcpr_pkg::S_MOVE_CHK: begin
                mem_we = 1'b1;
                mem_waddr = phys(r_head, CW'(r_idx) + CW'(1));
                mem_wdata = mem_rdata;
                n_idx = r_idx - AW'(1);
            end
            tcpr_pkg::S_PLACE: begin
                mem_we = 1'b1;
                n_count = r_count + CW'(1);
                n_push_kind = r_kind;
                n_done = 1'b1;
            end
            tcpr_pkg::S_POP_RD: begin
                mem_raddr = r_head;
            end
            tcpr_pkg::S_POP_CHK: begin
                n_done = 1'b1;
                if (!tcpr_pkg::seq_after(rd_seq, r_exp)) begin
                    n_popped = 1'b1;
                    n_res_seq = rd_seq;
                    n_res_len = rd_len;
                    n_res_kind = rd_kind;
                    n_res_hdl = rd_hdl;
                    n_res_stamp = rd_stamp;
                    n_head = phys(r_head, CW'(1));
                    n_count = r_count - CW'(1);
                    case (rd_kind)
                        tcpr_pkg::KIND_SYN, tcpr_pkg::KIND_FIN: n_exp = r_exp + 32'd1;
                        tcpr_pkg::KIND_DATA: n_exp = rd_end;
                        tcpr_pkg::KIND_RETRANSMIT: begin
                            if (tcpr_pkg::seq_after(rd_end, r_exp)) begin
                                n_exp = rd_end;
                            end
                        end
                        default: n_exp = r_exp;
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcpr_pkg::S_IDLE;
            r_head <= '0;
            r_count <= '0;
            r_exp <= '0;
            r_done <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head <= n_head;
            r_count <= n_count;
            r_exp <= n_exp;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_pos <= n_pos;
        r_seq <= n_seq;
        r_len <= n_len;
        r_kind <= n_kind;
        r_hdl <= n_hdl;
        r_stamp <= n_stamp;
        r_push_kind <= n_push_kind;
        r_dropped <= n_dropped;
        r_popped <= n_popped;
        r_res_seq <= n_res_seq;
        r_res_len <= n_res_len;
        r_res_kind <= n_res_kind;
        r_res_hdl <= n_res_hdl;
        r_res_stamp <= n_res_stamp;
    end

    assign o_done = r_done;
    assign o_push_kind = r_push_kind;
    assign o_dropped = r_dropped;
    assign o_popped = r_popped;
    assign o_out_seq = r_res_seq;
    assign o_out_len = r_res_len;
    assign o_out_kind = r_res_kind;
    assign o_out_handle = 16'(r_res_hdl);
    assign o_out_stamp = r_res_stamp;

endmodule

### hw/rtl/tcpr_checker.sv
module tcpr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [2:0]  o_push_kind,
    input logic        o_dropped,
    input logic        o_popped
);

    a_busy_needs_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without an accepted item");

    a_pop_not_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_popped) |-> (o_push_kind == tcpr_pkg::KIND_IGNORE && !o_dropped))
        else $error("released item carries a push verdict");

    a_drop_no_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_dropped) |-> (o_push_kind == tcpr_pkg::KIND_IGNORE))
        else $error("dropped item carries a push kind");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_done && !busy))
        else $error("activity right after reset");

endmodule

bind tcp_sequence_reorder_buffer tcpr_checker u_tcpr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_done      (o_done),
    .o_push_kind (o_push_kind),
    .o_dropped   (o_dropped),
    .o_popped    (o_popped)
);

### dv/tb_tcp_sequence_reorder_buffer.sv
`timescale 1ns / 100ps

module tb_tcp_sequence_reorder_buffer;

    localparam int DEPTH = 64;
    localparam int NUM_RANDOM = 1000;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct {
        logic        op;
        logic        acc;
        logic [31:0] seq;
        logic [15:0] tot;
        logic [3:0]  ihw;
        logic [3:0]  thw;
        logic        syn;
        logic        ack;
        logic        fin;
        logic        rst;
        logic [15:0] hnd;
        logic [31:0] stp;
    } t_item;

    typedef struct {
        logic [2:0]  push_kind;
        logic        dropped;
        logic        popped;
        logic [31:0] seq;
        logic [15:0] len;
        logic [2:0]  kind;
        logic [15:0] hnd;
        logic [31:0] stp;
    } t_verdict;

    typedef struct {
        logic [31:0] seq;
        logic [15:0] len;
        logic [2:0]  kind;
        logic [15:0] hnd;
        logic [31:0] stp;
    } t_record;

    typedef struct {
        t_item item;
        logic  has_check;
        logic  check_popped;
        logic [2:0] check_kind;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_operation;
    logic        i_accept;
    logic [31:0] i_seq_number;
    logic [15:0] i_ip_total_len;
    logic [3:0]  i_ip_header_words;
    logic [3:0]  i_tcp_header_words;
    logic        i_flag_syn;
    logic        i_flag_ack;
    logic        i_flag_fin;
    logic        i_flag_rst;
    logic [15:0] i_handle;
    logic [31:0] i_stamp;
    logic        o_done;
    logic [2:0]  o_push_kind;
    logic        o_dropped;
    logic        o_popped;
    logic [31:0] o_out_seq;
    logic [15:0] o_out_len;
    logic [2:0]  o_out_kind;
    logic [15:0] o_out_handle;
    logic [31:0] o_out_stamp;

    t_record  segment_store[$];
    logic [31:0] next_seq_expected;
    t_verdict pending_verdicts[$];
    int       mismatch_count;
    int       cycle_count;
    logic [31:0] cursor;

    tcp_sequence_reorder_buffer #(.STORE_DEPTH(DEPTH), .HANDLE_BITS(16)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_operation(i_operation), .i_accept(i_accept), .i_seq_number(i_seq_number),
        .i_ip_total_len(i_ip_total_len), .i_ip_header_words(i_ip_header_words),
        .i_tcp_header_words(i_tcp_header_words), .i_flag_syn(i_flag_syn),
        .i_flag_ack(i_flag_ack), .i_flag_fin(i_flag_fin), .i_flag_rst(i_flag_rst),
        .i_handle(i_handle), .i_stamp(i_stamp), .o_done(o_done),
        .o_push_kind(o_push_kind), .o_dropped(o_dropped), .o_popped(o_popped),
        .o_out_seq(o_out_seq), .o_out_len(o_out_len), .o_out_kind(o_out_kind),
        .o_out_handle(o_out_handle), .o_out_stamp(o_out_stamp)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic is_after(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return (d != 32'd0) && !d[31];
    endfunction

    function automatic t_verdict predict_segment(t_item it);
        t_verdict v;
        t_record r;
        tcpr_pkg::t_kind k;
        logic [17:0] hdr;
        logic [15:0] len;
        logic [31:0] tail_end;
        int pos;
        v = '{default: '0};
        if (!it.op) begin
            if (!it.acc) return v;
            hdr = 18'(it.ihw) * 18'd4 + 18'(it.thw) * 18'd4;
            len = ({2'b0, it.tot} > hdr) ? 16'({2'b0, it.tot} - hdr) : 16'd0;
            if (it.syn) begin
                k = tcpr_pkg::KIND_SYN;
                next_seq_expected = it.seq;
            end else if (it.ack && !it.fin && len == 16'd0) k = tcpr_pkg::KIND_ACK;
            else if (is_after(next_seq_expected, it.seq)) k = tcpr_pkg::KIND_RETRANSMIT;
            else if (it.fin) k = tcpr_pkg::KIND_FIN;
            else if (it.rst) k = tcpr_pkg::KIND_RST;
            else k = tcpr_pkg::KIND_DATA;
            if (segment_store.size() >= DEPTH) begin
                v.dropped = 1'b1;
                return v;
            end
            r = '{it.seq, len, k, it.hnd, it.stp};
            pos = segment_store.size();
            if (pos > 0 && is_after(segment_store[pos-1].seq, it.seq)
                    || pos > 0 && (it.seq - segment_store[pos-1].seq) == 32'h8000_0000) begin
                for (int i = 0; i < segment_store.size(); i++) begin
                    if (is_after(segment_store[i].seq, it.seq)) begin
                        pos = i;
                        break;
                    end
                end
            end
            segment_store.insert(pos, r);
            v.push_kind = k;
            return v;
        end
        if (segment_store.size() == 0 || is_after(segment_store[0].seq, next_seq_expected))
            return v;
        r = segment_store.pop_front();
        v.popped = 1'b1;
        v.seq = r.seq;
        v.len = r.len;
        v.kind = r.kind;
        v.hnd = r.hnd;
        v.stp = r.stp;
        tail_end = r.seq + 32'(r.len);
        if (r.kind == tcpr_pkg::KIND_SYN || r.kind == tcpr_pkg::KIND_FIN)
            next_seq_expected += 32'd1;
        else if (r.kind == tcpr_pkg::KIND_DATA) next_seq_expected = tail_end;
        else if (r.kind == tcpr_pkg::KIND_RETRANSMIT && is_after(tail_end, next_seq_expected))
            next_seq_expected = tail_end;
        return v;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("t=%0t %s: got %h expected %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_verdict w;
        if (i_rst_n) begin
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
        if (i_rst_n && o_done) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch("unexpected result", 32'd1, 32'd0);
            end else begin
                w = pending_verdicts.pop_front();
                if (o_push_kind !== w.push_kind)
                    report_mismatch("push_kind", 32'(o_push_kind), 32'(w.push_kind));
                if (o_dropped !== w.dropped)
                    report_mismatch("dropped", 32'(o_dropped), 32'(w.dropped));
                if (o_popped !== w.popped)
                    report_mismatch("popped", 32'(o_popped), 32'(w.popped));
                if (o_out_seq !== w.seq) report_mismatch("out_seq", o_out_seq, w.seq);
                if (o_out_len !== w.len)
                    report_mismatch("out_len", 32'(o_out_len), 32'(w.len));
                if (o_out_kind !== w.kind)
                    report_mismatch("out_kind", 32'(o_out_kind), 32'(w.kind));
                if (o_out_handle !== w.hnd)
                    report_mismatch("out_handle", 32'(o_out_handle), 32'(w.hnd));
                if (o_out_stamp !== w.stp) report_mismatch("out_stamp", o_out_stamp, w.stp);
            end
        end
    end

    task automatic send_segment(t_item it, logic has_check, logic chk_pop, logic [2:0] chk_kind);
        t_verdict v;
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
            : ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 3));
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_operation <= it.op;
        i_accept <= it.acc;
        i_seq_number <= it.seq;
        i_ip_total_len <= it.tot;
        i_ip_header_words <= it.ihw;
        i_tcp_header_words <= it.thw;
        i_flag_syn <= it.syn;
        i_flag_ack <= it.ack;
        i_flag_fin <= it.fin;
        i_flag_rst <= it.rst;
        i_handle <= it.hnd;
        i_stamp <= it.stp;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        v = predict_segment(it);
        if (has_check) begin
            if (chk_pop && v.popped !== 1'b1)
                report_mismatch("table popped", 32'(v.popped), 32'd1);
            if (!chk_pop && v.push_kind !== chk_kind)
                report_mismatch("table kind", 32'(v.push_kind), 32'(chk_kind));
        end
        pending_verdicts.push_back(v);
    endtask

    function automatic t_item make_push(logic [31:0] seq, logic [15:0] tot, logic syn,
                                        logic ack, logic fin, logic rst);
        t_item it;
        it = '{1'b0, 1'b1, seq, tot, 4'd5, 4'd5, syn, ack, fin, rst,
               16'($urandom), $urandom};
        return it;
    endfunction

    function automatic t_item make_pop();
        t_item it;
        it = '{default: '0};
        it.op = 1'b1;
        it.seq = $urandom;
        it.hnd = 16'($urandom);
        return it;
    endfunction

    function automatic t_item random_item();
        t_item it;
        int r;
        int span;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            it = make_pop();
        end else begin
            span = $urandom_range(0, 3);
            it = make_push(cursor + $urandom_range(0, 3000) - 1000,
                           16'($urandom_range(40, 1500)), 1'b0, 1'b0, 1'b0, 1'b0);
            if (r < 70) begin
                it.seq = cursor;
                it.tot = 16'(40 + 100 * span);
                cursor = cursor + 32'(100 * span);
            end
            it.syn = ($urandom_range(0, 30) == 0);
            if (it.syn) cursor = it.seq + 1;
            it.ack = $urandom_range(0, 3) == 0;
            it.fin = $urandom_range(0, 15) == 0;
            it.rst = $urandom_range(0, 15) == 0;
            it.acc = $urandom_range(0, 19) != 0;
            if ($urandom_range(0, 9) == 0) begin
                it.seq = $urandom;
                it.tot = 16'($urandom);
                it.ihw = 4'($urandom);
                it.thw = 4'($urandom);
            end
        end
        return it;
    endfunction

    initial begin
        t_row rows[$];
        t_item it;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_operation = 1'b0;
        i_accept = 1'b0;
        i_seq_number = '0;
        i_ip_total_len = '0;
        i_ip_header_words = '0;
        i_tcp_header_words = '0;
        i_flag_syn = 1'b0;
        i_flag_ack = 1'b0;
        i_flag_fin = 1'b0;
        i_flag_rst = 1'b0;
        i_handle = '0;
        i_stamp = '0;
        mismatch_count = 0;
        cycle_count = 0;
        next_seq_expected = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        rows.push_back('{make_pop(), 1'b0, 1'b0, tcpr_pkg::KIND_IGNORE});
        it = make_push(32'd100, 16'd60, 1'b0, 1'b0, 1'b0, 1'b0);
        it.acc = 1'b0;
        rows.push_back('{it, 1'b1, 1'b0, tcpr_pkg::KIND_IGNORE});
        rows.push_back('{make_push(32'hFFFF_FFF0, 16'd40, 1'b1, 1'b0, 1'b0, 1'b0),
                         1'b1, 1'b0, tcpr_pkg::KIND_SYN});
        rows.push_back('{make_push(32'hFFFF_FFF1, 16'd40, 1'b0, 1'b1, 1'b0, 1'b0),
                         1'b1, 1'b0, tcpr_pkg::KIND_ACK});
        rows.push_back('{make_push(32'h0000_0010, 16'd100, 1'b0, 1'b0, 1'b0, 1'b0),
                         1'b1, 1'b0, tcpr_pkg::KIND_DATA});
        rows.push_back('{make_push(32'hFFFF_FFF1, 16'hFFFF, 1'b0, 1'b1, 1'b0, 1'b0),
                         1'b1, 1'b0, tcpr_pkg::KIND_DATA});
        rows.push_back('{make_push(32'h8000_0000, 16'd40, 1'b0, 1'b0, 1'b1, 1'b1),
                         1'b0, 1'b0, tcpr_pkg::KIND_IGNORE});
        rows.push_back('{make_push(32'h7FFF_FFF1, 16'd50, 1'b0, 1'b0, 1'b0, 1'b0),
                         1'b0, 1'b0, tcpr_pkg::KIND_IGNORE});
        rows.push_back('{make_push(32'hFFFF_FF00, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1),
                         1'b1, 1'b0, tcpr_pkg::KIND_RETRANSMIT});
        rows.push_back('{make_push(32'hFFFF_FFF1, 16'd45, 1'b0, 1'b1, 1'b1, 1'b0),
                         1'b1, 1'b0, tcpr_pkg::KIND_FIN});
        rows.push_back('{make_push(32'hFFFF_FFF2, 16'd40, 1'b0, 1'b0, 1'b0, 1'b1),
                         1'b1, 1'b0, tcpr_pkg::KIND_RST});
        it = make_push(32'hFFFF_FFF3, 16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b0);
        it.ihw = 4'hF;
        it.thw = 4'hF;
        it.hnd = 16'hFFFF;
        it.stp = 32'hFFFF_FFFF;
        rows.push_back('{it, 1'b1, 1'b0, tcpr_pkg::KIND_DATA});
        repeat (13) rows.push_back('{make_pop(), 1'b0, 1'b0, tcpr_pkg::KIND_IGNORE});
        foreach (rows[i]) send_segment(rows[i].item, rows[i].has_check,
                                       rows[i].check_popped, rows[i].check_kind);

        // Fill the store beyond its depth, then send DEPTH + 2 pops to release what it can.
        cursor = next_seq_expected;
        for (int i = 0; i < DEPTH + 3; i++)
            send_segment(make_push(cursor + 32'($urandom_range(0, 500)), 16'd40,
                                   1'b0, 1'b0, 1'b0, 1'b0), 1'b0, 1'b0,
                         tcpr_pkg::KIND_IGNORE);
        it = make_push(cursor + 5, 16'd40, 1'b1, 1'b0, 1'b0, 1'b0);
        send_segment(it, 1'b0, 1'b0, tcpr_pkg::KIND_IGNORE);
        repeat (DEPTH + 2) send_segment(make_pop(), 1'b0, 1'b0, tcpr_pkg::KIND_IGNORE);

        cursor = next_seq_expected;
        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (segment_store.size() > 40 || $urandom_range(0, 99) == 0) cursor = next_seq_expected;
            send_segment(random_item(), 1'b0, 1'b0, tcpr_pkg::KIND_IGNORE);
        end
        start <= 1'b0;

        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
